>>> src/gf2inv_pkg.sv
// Shared types and constants for the GF(2) divstep polynomial inverter.
`default_nettype none
package gf2inv_pkg;

	localparam int FIELD_W = 64;
	localparam int CNT_W   = 7;
	localparam int DELTA_W = 9;

	localparam logic [CNT_W-1:0] STEP_COUNT_RST = 7'd127;

	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic [CNT_W-1:0]          cnt_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

endpackage
`default_nettype wire

>>> src/gf2_poly_divstep_inverse.sv
// Top level: GF(2) polynomial inversion by constant-time divsteps.
//
// Input channel (in_valid / in_stall) carries f and g as low and high words;
// only the low HALF_WIDTH bits of each word are used. A request is taken
// when in_valid is high and in_stall is low. The output channel
// (out_valid / out_stall) returns the final v and the final f, zero-extended.
// The user must see that step_count is written through cfg_we / cfg_wdata
// only while the block is idle; the block itself does not enforce this.
//
// One divstep is done per cycle by a single shared step unit under a small
// sequencer: an accepted request runs step_count divsteps in state RUN, then
// waits in state HOLD until the output register is free and takes its result.
// No new request is accepted while one is in RUN or HOLD. A step count of
// zero skips the unit entirely. The output register lets a new request be
// accepted while a result waits; if that next result finishes before the old
// one is taken, the sequencer holds it and in_stall stays high until the
// output register frees.
// Reset (arst_n low) empties the output register, returns the sequencer to
// idle and sets step_count to 127.
`default_nettype none
module gf2_poly_divstep_inverse
	import gf2inv_pkg::*;
#(
	parameter int HALF_WIDTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CNT_W-1:0]   cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [FIELD_W-1:0] f_lo,
	input  wire logic [FIELD_W-1:0] f_hi,
	input  wire logic [FIELD_W-1:0] g_lo,
	input  wire logic [FIELD_W-1:0] g_hi,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [FIELD_W-1:0]      v_lo,
	output logic [FIELD_W-1:0]      v_hi,
	output logic [FIELD_W-1:0]      final_f_lo,
	output logic [FIELD_W-1:0]      final_f_hi
);

	localparam int PW = 2 * HALF_WIDTH;

	state_t          state_q;
	cnt_t            step_count_q;
	cnt_t            step_idx_q;
	delta_t          delta_q;
	logic [PW-1:0]   f_q, g_q, u_q, v_q, q_q, r_q;
	logic [PW-1:0]   vout_q, fout_q;
	logic            out_valid_q;

	logic            in_acc, out_free, last_step;
	logic            sw, f0, g0;
	logic [PW-1:0]   fs, gs, us, vs, qs, rs, gx;
	logic [PW-1:0]   f_nx, g_nx, u_nx, v_nx, q_nx, r_nx;
	delta_t          delta_nx;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign last_step = (step_idx_q == step_count_q - cnt_t'(1));

	// shared divstep unit
	always_comb begin
		sw = (delta_q > delta_t'(0)) && g_q[0];
		fs = sw ? g_q : f_q;
		gs = sw ? f_q : g_q;
		qs = sw ? u_q : q_q;
		us = sw ? q_q : u_q;
		rs = sw ? v_q : r_q;
		vs = sw ? r_q : v_q;
		delta_nx = (sw ? -delta_q : delta_q) + delta_t'(1);
		f0 = fs[0];
		g0 = gs[0];
		gx   = ({PW{f0}} & gs) ^ ({PW{g0}} & fs);
		q_nx = ({PW{f0}} & qs) ^ ({PW{g0}} & us);
		r_nx = ({PW{f0}} & rs) ^ ({PW{g0}} & vs);
		g_nx = {1'b0, gx[PW-1:1]};
		f_nx = fs;
		u_nx = {us[PW-2:0], 1'b0};
		v_nx = {vs[PW-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_count_q <= STEP_COUNT_RST;
			step_idx_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				step_count_q <= cfg_wdata;
			end
			if (state_q == ST_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						step_idx_q <= '0;
						state_q    <= (step_count_q == '0) ? ST_HOLD : ST_RUN;
					end
				end
				ST_RUN: begin
					step_idx_q <= step_idx_q + cnt_t'(1);
					if (last_step) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers and output register, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			f_q     <= {f_hi[HALF_WIDTH-1:0], f_lo[HALF_WIDTH-1:0]};
			g_q     <= {g_hi[HALF_WIDTH-1:0], g_lo[HALF_WIDTH-1:0]};
			u_q     <= PW'(1);
			v_q     <= '0;
			q_q     <= '0;
			r_q     <= PW'(1);
			delta_q <= delta_t'(1);
		end else if (state_q == ST_RUN) begin
			f_q     <= f_nx;
			g_q     <= g_nx;
			u_q     <= u_nx;
			v_q     <= v_nx;
			q_q     <= q_nx;
			r_q     <= r_nx;
			delta_q <= delta_nx;
		end
		if (state_q == ST_HOLD && out_free) begin
			vout_q <= v_q;
			fout_q <= f_q;
		end
	end

	assign v_lo       = FIELD_W'(vout_q[HALF_WIDTH-1:0]);
	assign v_hi       = FIELD_W'(vout_q[PW-1:HALF_WIDTH]);
	assign final_f_lo = FIELD_W'(fout_q[HALF_WIDTH-1:0]);
	assign final_f_hi = FIELD_W'(fout_q[PW-1:HALF_WIDTH]);

	a_run_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_idx_q < step_count_q))
		else $error("step index beyond step count");

	a_delta_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ($signed(delta_q) >= -127 && $signed(delta_q) <= 128))
		else $error("delta out of range");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_RUN || state_q == ST_HOLD))
		else $error("request accepted but sequencer not started");

	a_hold_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("held result not moved to output");

endmodule
`default_nettype wire
